@@ sv/scpb_pkg.sv @@
`timescale 1ns / 1ps

package scpb_pkg;

    // Geometry and colour widths
    localparam int COORD_BITS    = 12;
    localparam int COLOR_BITS    = 8;
    localparam int RAD_BITS      = 8;
    localparam int NUM_CHAN      = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = (COORD_BITS > COLOR_BITS) ? COORD_BITS : COLOR_BITS;

    // Distance squared, full and inside-circle (below radius squared)
    localparam int DIST2_BITS = 2 * COORD_BITS + 1;
    localparam int DIST_BITS  = 2 * RAD_BITS;

    // Square root: radicand = dist2 << 16, root has 8 fraction bits
    localparam int FRAC_BITS   = 8;
    localparam int ROOT_BITS   = DIST_BITS;
    localparam int SQ_IN_BITS  = 2 * ROOT_BITS;
    localparam int SQ_REM_BITS = ROOT_BITS + 3;
    localparam int SQ_STEP     = 2;
    localparam int SQ_STAGES   = ROOT_BITS / SQ_STEP;

    // Divider: ((r << 8) - d8) << 8, divided by r
    localparam int DIVD_BITS  = ROOT_BITS + FRAC_BITS;
    localparam int Q_BITS     = 18;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = Q_BITS / DIV_STEP;
    localparam int T_BITS     = 17;

    // Blend
    localparam int FACT_BITS = 17;
    localparam int PROD_BITS = COLOR_BITS + 1 + FACT_BITS;
    localparam int FACT_MAX  = 65280;

    // Reset values
    localparam logic [RAD_BITS-1:0]   RADIUS_RESET  = 8'd30;
    localparam logic [COLOR_BITS-1:0] OPACITY_RESET = 8'd51;

    typedef logic [NUM_CHAN-1:0][COLOR_BITS-1:0] t_rgb;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_RADIUS,
        CFG_PAINT_RED,
        CFG_PAINT_GREEN,
        CFG_PAINT_BLUE,
        CFG_OPACITY
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [RAD_BITS-1:0]   radius;
        t_rgb                  paint;
        logic [COLOR_BITS-1:0] opacity;
    } t_cfg;

    // Sideband that rides alongside the arithmetic
    typedef struct packed {
        logic hit;
        t_rgb pix;
    } t_side;

endpackage

@@ sv/soft_circle_pixel_blend.sv @@
`timescale 1ns / 1ps
// Soft circle pixel blend.
// A pixel transaction (column, row, RGB) is offered on start; it is taken at
// any rising edge with start high and busy low. busy is held low: the
// pipeline takes one pixel every cycle without a gap.
// Each pixel gives exactly one result on o_out_* / o_inside_circle, shown
// for one cycle with o_valid high. The pipeline is a chain of 3 distance
// stages, 8 square-root stages (two root bits each), 9 divider stages (two
// quotient bits each) and 4 blend stages. Results leave in input order.
// The receiver cannot stall; o_valid is a strobe and must be caught.
// The circle registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data, with no wait and no read-back. Unknown indices are ignored.
// The user must write only while no pixel is in flight; it is not enforced.
// Synchronous active-low reset empties the pipeline and restores the
// register defaults (radius 30, opacity 51, all else zero).

module soft_circle_pixel_blend (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [scpb_pkg::COORD_BITS-1:0]      i_pixel_x,
    input  logic [scpb_pkg::COORD_BITS-1:0]      i_pixel_y,
    input  logic [scpb_pkg::COLOR_BITS-1:0]      i_in_red,
    input  logic [scpb_pkg::COLOR_BITS-1:0]      i_in_green,
    input  logic [scpb_pkg::COLOR_BITS-1:0]      i_in_blue,
    input  logic                                 i_cfg_we,
    input  logic [scpb_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [scpb_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output logic                                 o_valid,
    output logic [scpb_pkg::COLOR_BITS-1:0]      o_out_red,
    output logic [scpb_pkg::COLOR_BITS-1:0]      o_out_green,
    output logic [scpb_pkg::COLOR_BITS-1:0]      o_out_blue,
    output logic                                 o_inside_circle
);
    import scpb_pkg::*;

    // Channel order in t_rgb: red, green, blue
    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;

    t_cfg  r_cfg;
    t_rgb  in_pix;
    logic  accept;

    // distance stage outputs
    logic                  d_valid;
    logic [DIST_BITS-1:0]  d_dist2;
    t_side                 d_side;
    // square-root outputs
    logic                  s_valid;
    logic [ROOT_BITS-1:0]  s_root;
    t_side                 s_side;
    // divider outputs
    logic                  q_valid;
    logic [T_BITS-1:0]     q_t16;
    t_side                 q_side;
    // blend outputs
    t_rgb                  m_rgb;

    // No back-pressure anywhere: a pixel enters every cycle start is high
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        in_pix       = '0;
        in_pix[CH_R] = i_in_red;
        in_pix[CH_G] = i_in_green;
        in_pix[CH_B] = i_in_blue;
    end

    // Circle registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x <= '0;
            r_cfg.center_y <= '0;
            r_cfg.radius   <= RADIUS_RESET;
            r_cfg.paint    <= '0;
            r_cfg.opacity  <= OPACITY_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X:    r_cfg.center_x    <= i_cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Y:    r_cfg.center_y    <= i_cfg_data[COORD_BITS-1:0];
                CFG_RADIUS:      r_cfg.radius      <= i_cfg_data[RAD_BITS-1:0];
                CFG_PAINT_RED:   r_cfg.paint[CH_R] <= i_cfg_data[COLOR_BITS-1:0];
                CFG_PAINT_GREEN: r_cfg.paint[CH_G] <= i_cfg_data[COLOR_BITS-1:0];
                CFG_PAINT_BLUE:  r_cfg.paint[CH_B] <= i_cfg_data[COLOR_BITS-1:0];
                CFG_OPACITY:     r_cfg.opacity     <= i_cfg_data[COLOR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // |dx|, |dy|, squares, sum and the inside test against r squared
    scpb_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_px    (i_pixel_x),
        .i_py    (i_pixel_y),
        .i_pix   (in_pix),
        .i_cfg   (r_cfg),
        .o_valid (d_valid),
        .o_dist2 (d_dist2),
        .o_side  (d_side)
    );

    // d8 = floor(sqrt(dist2 << 16)); only meaningful for inside pixels
    scpb_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .i_dist2 (d_dist2),
        .i_side  (d_side),
        .i_cfg   (r_cfg),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    // t16 = (((r << 8) - d8) << 8) / r, i.e. 1 - d/r in Q.16
    scpb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .i_root  (s_root),
        .i_side  (s_side),
        .i_cfg   (r_cfg),
        .o_valid (q_valid),
        .o_t16   (q_t16),
        .o_side  (q_side)
    );

    // square, opacity scale, per-channel blend, output register
    scpb_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_t16    (q_t16),
        .i_side   (q_side),
        .i_cfg    (r_cfg),
        .o_valid  (o_valid),
        .o_rgb    (m_rgb),
        .o_inside (o_inside_circle)
    );

    assign o_out_red   = m_rgb[CH_R];
    assign o_out_green = m_rgb[CH_G];
    assign o_out_blue  = m_rgb[CH_B];

    // Inside flag is only ever raised alongside the strobe
    a_inside_with_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_inside_circle |-> o_valid)
        else $error("inside flag without result strobe");

endmodule

@@ sv/scpb_dist.sv @@
`timescale 1ns / 1ps

module scpb_dist (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [scpb_pkg::COORD_BITS-1:0]   i_px,
    input  logic [scpb_pkg::COORD_BITS-1:0]   i_py,
    input  scpb_pkg::t_rgb                    i_pix,
    input  scpb_pkg::t_cfg                    i_cfg,
    output logic                              o_valid,
    output logic [scpb_pkg::DIST_BITS-1:0]    o_dist2,
    output scpb_pkg::t_side                   o_side
);
    import scpb_pkg::*;

    logic                    r_v1, r_v2, r_v3;
    logic [COORD_BITS-1:0]   r_adx, r_ady;
    logic [2*COORD_BITS-1:0] r_sqx, r_sqy;
    t_rgb                    r_pix1, r_pix2;
    logic [DIST_BITS-1:0]    r_r2;
    logic [DIST_BITS-1:0]    r_dist2;
    t_side                   r_side;

    logic [COORD_BITS-1:0] n_adx, n_ady;
    logic [DIST2_BITS-1:0] n_dist2;

    always_comb begin
        n_adx   = (i_px >= i_cfg.center_x) ? i_px - i_cfg.center_x : i_cfg.center_x - i_px;
        n_ady   = (i_py >= i_cfg.center_y) ? i_py - i_cfg.center_y : i_cfg.center_y - i_py;
        n_dist2 = DIST2_BITS'(r_sqx) + DIST2_BITS'(r_sqy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_r2         <= DIST_BITS'(i_cfg.radius) * DIST_BITS'(i_cfg.radius);
        r_adx        <= n_adx;
        r_ady        <= n_ady;
        r_pix1       <= i_pix;
        r_sqx        <= (2*COORD_BITS)'(r_adx) * (2*COORD_BITS)'(r_adx);
        r_sqy        <= (2*COORD_BITS)'(r_ady) * (2*COORD_BITS)'(r_ady);
        r_pix2       <= r_pix1;
        // strictly inside; zero radius gives zero r2 so nothing is inside
        r_side.hit   <= (n_dist2 < DIST2_BITS'(r_r2));
        r_side.pix   <= r_pix2;
        r_dist2      <= n_dist2[DIST_BITS-1:0];
    end

    assign o_valid = r_v3;
    assign o_dist2 = r_dist2;
    assign o_side  = r_side;

endmodule

@@ sv/scpb_sqrt.sv @@
`timescale 1ns / 1ps

module scpb_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [scpb_pkg::DIST_BITS-1:0]    i_dist2,
    input  scpb_pkg::t_side                   i_side,
    input  scpb_pkg::t_cfg                    i_cfg,
    output logic                              o_valid,
    output logic [scpb_pkg::ROOT_BITS-1:0]    o_root,
    output scpb_pkg::t_side                   o_side
);
    import scpb_pkg::*;

    // Restoring square root, two result bits per stage
    logic                   r_v    [SQ_STAGES];
    logic [SQ_REM_BITS-1:0] r_rem  [SQ_STAGES];
    logic [ROOT_BITS-1:0]   r_root [SQ_STAGES];
    logic [SQ_IN_BITS-1:0]  r_rad  [SQ_STAGES];
    t_side                  r_side [SQ_STAGES];

    logic                   w_v    [SQ_STAGES];
    logic [SQ_REM_BITS-1:0] w_rem  [SQ_STAGES];
    logic [ROOT_BITS-1:0]   w_root [SQ_STAGES];
    logic [SQ_IN_BITS-1:0]  w_rad  [SQ_STAGES];
    t_side                  w_side [SQ_STAGES];

    logic [SQ_REM_BITS-1:0] n_rem  [SQ_STAGES];
    logic [ROOT_BITS-1:0]   n_root [SQ_STAGES];
    logic [SQ_IN_BITS-1:0]  n_rad  [SQ_STAGES];

    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
        logic [SQ_REM_BITS-1:0] l_rem;
        logic [ROOT_BITS-1:0]   l_root;
        logic [SQ_IN_BITS-1:0]  l_rad;

        if (s == 0) begin : g_first
            assign w_v[s]    = i_valid;
            assign w_rem[s]  = '0;
            assign w_root[s] = '0;
            assign w_rad[s]  = {i_dist2, {(SQ_IN_BITS-DIST_BITS){1'b0}}};
            assign w_side[s] = i_side;
        end else begin : g_next
            assign w_v[s]    = r_v[s-1];
            assign w_rem[s]  = r_rem[s-1];
            assign w_root[s] = r_root[s-1];
            assign w_rad[s]  = r_rad[s-1];
            assign w_side[s] = r_side[s-1];
        end

        always_comb begin
            logic [SQ_REM_BITS-1:0] trial;
            l_rem  = w_rem[s];
            l_root = w_root[s];
            l_rad  = w_rad[s];
            for (int j = 0; j < SQ_STEP; j++) begin
                l_rem = {l_rem[SQ_REM_BITS-3:0], l_rad[SQ_IN_BITS-1 -: 2]};
                l_rad = {l_rad[SQ_IN_BITS-3:0], 2'b00};
                trial = SQ_REM_BITS'({l_root, 2'b01});
                if (l_rem >= trial) begin
                    l_rem  = l_rem - trial;
                    l_root = {l_root[ROOT_BITS-2:0], 1'b1};
                end else begin
                    l_root = {l_root[ROOT_BITS-2:0], 1'b0};
                end
            end
        end

        assign n_rem[s]  = l_rem;
        assign n_root[s] = l_root;
        assign n_rad[s]  = l_rad;
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SQ_STAGES; s++) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= w_v[s];
            end
            r_rem[s]  <= n_rem[s];
            r_root[s] <= n_root[s];
            r_rad[s]  <= n_rad[s];
            r_side[s] <= w_side[s];
        end
    end

    assign o_valid = r_v[SQ_STAGES-1];
    assign o_root  = r_root[SQ_STAGES-1];
    assign o_side  = r_side[SQ_STAGES-1];

    // Distance of an inside pixel stays below the radius
    a_root_below_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_side.hit) |-> (o_root < {i_cfg.radius, {FRAC_BITS{1'b0}}}))
        else $error("root not below radius for inside pixel");

endmodule

@@ sv/scpb_div.sv @@
`timescale 1ns / 1ps

module scpb_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [scpb_pkg::ROOT_BITS-1:0]    i_root,
    input  scpb_pkg::t_side                   i_side,
    input  scpb_pkg::t_cfg                    i_cfg,
    output logic                              o_valid,
    output logic [scpb_pkg::T_BITS-1:0]       o_t16,
    output scpb_pkg::t_side                   o_side
);
    import scpb_pkg::*;

    // Restoring divide by the radius, two quotient bits per stage
    logic                  r_v    [DIV_STAGES];
    logic [RAD_BITS-1:0]   r_rem  [DIV_STAGES];
    logic [Q_BITS-1:0]     r_q    [DIV_STAGES];
    logic [Q_BITS-1:0]     r_num  [DIV_STAGES];
    t_side                 r_side [DIV_STAGES];

    logic                  w_v    [DIV_STAGES];
    logic [RAD_BITS-1:0]   w_rem  [DIV_STAGES];
    logic [Q_BITS-1:0]     w_q    [DIV_STAGES];
    logic [Q_BITS-1:0]     w_num  [DIV_STAGES];
    t_side                 w_side [DIV_STAGES];

    logic [RAD_BITS-1:0]   n_rem  [DIV_STAGES];
    logic [Q_BITS-1:0]     n_q    [DIV_STAGES];
    logic [Q_BITS-1:0]     n_num  [DIV_STAGES];

    logic [ROOT_BITS-1:0]  diff;
    logic [DIVD_BITS-1:0]  dividend;

    // (r << 8) - d8, shifted up by 8; for inside pixels the top bits are below r
    assign diff     = {i_cfg.radius, {FRAC_BITS{1'b0}}} - i_root;
    assign dividend = {diff, {FRAC_BITS{1'b0}}};

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [RAD_BITS-1:0] l_rem;
        logic [Q_BITS-1:0]   l_q;
        logic [Q_BITS-1:0]   l_num;

        if (s == 0) begin : g_first
            assign w_v[s]    = i_valid;
            assign w_rem[s]  = RAD_BITS'(dividend[DIVD_BITS-1:Q_BITS]);
            assign w_q[s]    = '0;
            assign w_num[s]  = dividend[Q_BITS-1:0];
            assign w_side[s] = i_side;
        end else begin : g_next
            assign w_v[s]    = r_v[s-1];
            assign w_rem[s]  = r_rem[s-1];
            assign w_q[s]    = r_q[s-1];
            assign w_num[s]  = r_num[s-1];
            assign w_side[s] = r_side[s-1];
        end

        always_comb begin
            logic [RAD_BITS:0] sh;
            l_rem = w_rem[s];
            l_q   = w_q[s];
            l_num = w_num[s];
            for (int j = 0; j < DIV_STEP; j++) begin
                sh    = {l_rem, l_num[Q_BITS-1]};
                l_num = {l_num[Q_BITS-2:0], 1'b0};
                if (sh >= {1'b0, i_cfg.radius}) begin
                    l_rem = RAD_BITS'(sh - {1'b0, i_cfg.radius});
                    l_q   = {l_q[Q_BITS-2:0], 1'b1};
                end else begin
                    l_rem = sh[RAD_BITS-1:0];
                    l_q   = {l_q[Q_BITS-2:0], 1'b0};
                end
            end
        end

        assign n_rem[s] = l_rem;
        assign n_q[s]   = l_q;
        assign n_num[s] = l_num;
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= w_v[s];
            end
            r_rem[s]  <= n_rem[s];
            r_q[s]    <= n_q[s];
            r_num[s]  <= n_num[s];
            r_side[s] <= w_side[s];
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_t16   = r_q[DIV_STAGES-1][T_BITS-1:0];
    assign o_side  = r_side[DIV_STAGES-1];

    // 1 - d/r never exceeds one, so the quotient fits T_BITS
    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_side.hit) |-> (r_q[DIV_STAGES-1][Q_BITS-1] == 1'b0))
        else $error("quotient overflow for inside pixel");

endmodule

@@ sv/scpb_mix.sv @@
`timescale 1ns / 1ps

module scpb_mix (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [scpb_pkg::T_BITS-1:0]       i_t16,
    input  scpb_pkg::t_side                   i_side,
    input  scpb_pkg::t_cfg                    i_cfg,
    output logic                              o_valid,
    output scpb_pkg::t_rgb                    o_rgb,
    output logic                              o_inside
);
    import scpb_pkg::*;

    logic                        r_v1, r_v2, r_v3, r_v4;
    t_side                       r_side1, r_side2, r_side3;
    logic [T_BITS-1:0]           r_t2;
    logic [FACT_BITS-1:0]        r_fac;
    logic signed [PROD_BITS-1:0] r_prod [NUM_CHAN];
    t_rgb                        r_rgb;
    logic                        r_inside;

    logic [2*T_BITS-1:0]             sq;
    logic [T_BITS+COLOR_BITS-1:0]    scaled;
    logic signed [PROD_BITS-1:0]     n_prod [NUM_CHAN];
    t_rgb                            n_rgb;

    assign sq     = (2*T_BITS)'(i_t16) * (2*T_BITS)'(i_t16);
    assign scaled = (T_BITS+COLOR_BITS)'(r_t2) * (T_BITS+COLOR_BITS)'(i_cfg.opacity);

    always_comb begin
        logic signed [COLOR_BITS:0]  diff;
        logic signed [PROD_BITS-1:0] sum;
        for (int c = 0; c < NUM_CHAN; c++) begin
            diff      = $signed({1'b0, i_cfg.paint[c]}) - $signed({1'b0, r_side2.pix[c]});
            n_prod[c] = PROD_BITS'(diff) * $signed({{(PROD_BITS-FACT_BITS){1'b0}}, r_fac});
        end
        for (int c = 0; c < NUM_CHAN; c++) begin
            // pix*(1-f) + paint*f == pix + (paint-pix)*f, with 16 fraction bits
            sum = $signed({{(PROD_BITS-COLOR_BITS-16){1'b0}}, r_side3.pix[c], 16'h0000})
                + r_prod[c];
            n_rgb[c] = r_side3.hit ? sum[16 +: COLOR_BITS] : r_side3.pix[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_inside <= 1'b0;
        end else begin
            r_v1     <= i_valid;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
            r_inside <= r_v3 && r_side3.hit;
        end
        r_t2    <= sq[T_BITS+15:16];
        r_side1 <= i_side;
        r_fac   <= scaled[FACT_BITS+7:8];
        r_side2 <= r_side1;
        for (int c = 0; c < NUM_CHAN; c++) begin
            r_prod[c] <= n_prod[c];
        end
        r_side3 <= r_side2;
        r_rgb   <= n_rgb;
    end

    assign o_valid  = r_v4;
    assign o_rgb    = r_rgb;
    assign o_inside = r_inside;

    // Factor of an inside pixel never reaches one
    a_fac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_side2.hit) |-> (r_fac <= FACT_BITS'(FACT_MAX)))
        else $error("blend factor out of range");

endmodule

@@ dv/soft_circle_pixel_blend_tb.sv @@
`timescale 1ns / 1ps

module soft_circle_pixel_blend_tb;

    import scpb_pkg::*;

    // Run limits
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int PIPE_LATENCY  = 24;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int RAND_SETTINGS = 10;
    localparam int PIXELS_PER    = 45;

    // Register index past the end of the map; writes to it must be dropped
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_IDX = 3'd7;

    localparam int COORD_MAX = (1 << COORD_BITS) - 1;
    localparam int LEVEL_MAX = (1 << COLOR_BITS) - 1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic                  hit;
    } t_blend;

    // Mirror of the circle registers
    typedef struct packed {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [RAD_BITS-1:0]   radius;
        logic [COLOR_BITS-1:0] paint_r;
        logic [COLOR_BITS-1:0] paint_g;
        logic [COLOR_BITS-1:0] paint_b;
        logic [COLOR_BITS-1:0] opacity;
    } t_circle;

    // Directed stimulus: either a register write or a pixel, the latter
    // optionally carrying a hand-worked result
    typedef enum logic {ROW_WRITE, ROW_PIXEL} t_row_kind;

    typedef struct {
        t_row_kind                kind;
        logic [CFG_IDX_BITS-1:0]  reg_idx;
        logic [CFG_DATA_BITS-1:0] reg_val;
        t_pixel                   pix;
        bit                       known;
        t_blend                   want;
    } t_stim_row;

    // DUT signals
    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [COORD_BITS-1:0]     i_pixel_x;
    logic [COORD_BITS-1:0]     i_pixel_y;
    logic [COLOR_BITS-1:0]     i_in_red;
    logic [COLOR_BITS-1:0]     i_in_green;
    logic [COLOR_BITS-1:0]     i_in_blue;
    logic                      i_cfg_we;
    logic [CFG_IDX_BITS-1:0]   i_cfg_idx;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;
    logic                      o_valid;
    logic [COLOR_BITS-1:0]     o_out_red;
    logic [COLOR_BITS-1:0]     o_out_green;
    logic [COLOR_BITS-1:0]     o_out_blue;
    logic                      o_inside_circle;

    // Checker state
    t_circle   circle_regs;
    t_blend    pending_blends[$];
    bit        cur_known;
    t_blend    cur_want;
    int        error_count;
    int        cycle_count;
    int        result_count;
    int        inside_count;
    int        pixel_count;
    int        setting_count;
    int        burst_left;
    t_stim_row directed[$];

    soft_circle_pixel_blend dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_in_red        (i_in_red),
        .i_in_green      (i_in_green),
        .i_in_blue       (i_in_blue),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_out_red       (o_out_red),
        .o_out_green     (o_out_green),
        .o_out_blue      (o_out_blue),
        .o_inside_circle (o_inside_circle)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Blend predictor
    // ------------------------------------------------------------------

    // One channel: weighted mix of pixel and paint, factor in Q0.16
    function automatic logic [COLOR_BITS-1:0] mix_level(
        logic [COLOR_BITS-1:0] pix, logic [COLOR_BITS-1:0] paint, longint unsigned factor);
        longint unsigned acc;
        acc = (longint'(pix) * (64'd65536 - factor) + longint'(paint) * factor) >> 16;
        return acc[COLOR_BITS-1:0];
    endfunction

    function automatic t_blend blend_predict(t_pixel p, t_circle c);
        longint unsigned adx, ady, dist2, rad, radicand, cand, d8, t16, t2, factor;
        t_blend res;
        adx = (p.x >= c.cx) ? longint'(p.x) - longint'(c.cx) : longint'(c.cx) - longint'(p.x);
        ady = (p.y >= c.cy) ? longint'(p.y) - longint'(c.cy) : longint'(c.cy) - longint'(p.y);
        dist2 = adx * adx + ady * ady;
        rad = c.radius;
        // On or outside the rim (or no circle at all): pass straight through
        if (rad == 0 || dist2 >= rad * rad) begin
            res = '{red: p.red, green: p.green, blue: p.blue, hit: 1'b0};
            return res;
        end
        // Distance with 8 fraction bits: floor root of dist2 * 2^16,
        // built one bit at a time from the top (root stays below 2^16)
        radicand = dist2 << 16;
        d8 = 0;
        for (int b = 15; b >= 0; b--) begin
            cand = d8 | (64'd1 << b);
            if (cand * cand <= radicand) d8 = cand;
        end
        t16    = (((rad << 8) - d8) << 8) / rad;
        t2     = (t16 * t16) >> 16;
        factor = (t2 * longint'(c.opacity)) >> 8;
        res.red    = mix_level(p.red,   c.paint_r, factor);
        res.green  = mix_level(p.green, c.paint_g, factor);
        res.blue   = mix_level(p.blue,  c.paint_b, factor);
        res.hit    = 1'b1;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
                 result_count, what, got, want);
        error_count++;
    endtask

    // Everything is sampled at the rising edge; inputs only move on the
    // falling edge, so nothing here races the driver.
    // Order within an edge: check a result, then log a new transaction,
    // then follow a register write. A result at the edge that took its
    // own pixel would thus show up as unexpected, not pass by accident.
    always @(posedge i_clk) begin
        t_blend want;
        t_pixel taken;
        cycle_count++;
        if (!i_rst_n) begin
            circle_regs <= '{cx: '0, cy: '0, radius: RADIUS_RESET, paint_r: '0,
                             paint_g: '0, paint_b: '0, opacity: OPACITY_RESET};
        end else begin
            if (o_valid) begin
                result_count++;
                if (o_inside_circle) inside_count++;
                if (pending_blends.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 1, 0);
                end else begin
                    want = pending_blends.pop_front();
                    if (o_out_red !== want.red)
                        report_mismatch("out_red", o_out_red, want.red);
                    if (o_out_green !== want.green)
                        report_mismatch("out_green", o_out_green, want.green);
                    if (o_out_blue !== want.blue)
                        report_mismatch("out_blue", o_out_blue, want.blue);
                    if (o_inside_circle !== want.hit)
                        report_mismatch("inside_circle", o_inside_circle, want.hit);
                end
            end
            if (start && !busy) begin
                taken = '{x: i_pixel_x, y: i_pixel_y, red: i_in_red,
                          green: i_in_green, blue: i_in_blue};
                pending_blends.push_back(cur_known ? cur_want
                                                   : blend_predict(taken, circle_regs));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CENTER_X:    circle_regs.cx      <= i_cfg_data;
                    CFG_CENTER_Y:    circle_regs.cy      <= i_cfg_data;
                    CFG_RADIUS:      circle_regs.radius  <= i_cfg_data[RAD_BITS-1:0];
                    CFG_PAINT_RED:   circle_regs.paint_r <= i_cfg_data[COLOR_BITS-1:0];
                    CFG_PAINT_GREEN: circle_regs.paint_g <= i_cfg_data[COLOR_BITS-1:0];
                    CFG_PAINT_BLUE:  circle_regs.paint_b <= i_cfg_data[COLOR_BITS-1:0];
                    CFG_OPACITY:     circle_regs.opacity <= i_cfg_data[COLOR_BITS-1:0];
                    default: ;  // past the map: dropped
                endcase
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycle_count, pending_blends.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving (all on the falling edge)
    // ------------------------------------------------------------------

    // Offer one pixel and hold it until the block takes it
    task automatic send_pixel(t_pixel p, bit known, t_blend want);
        @(negedge i_clk);
        start      = 1'b1;
        i_pixel_x  = p.x;
        i_pixel_y  = p.y;
        i_in_red   = p.red;
        i_in_green = p.green;
        i_in_blue  = p.blue;
        cur_known  = known;
        cur_want   = want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pixel_count++;
    endtask

    task automatic idle_for(int cycles);
        @(negedge i_clk);
        start = 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Bursty sender: short bursts with gaps, now and then a long gapless run
    task automatic pace_sender();
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(30, 80);
            else                            burst_left = $urandom_range(1, 12);
            idle_for($urandom_range(1, 6));
        end
        burst_left--;
    endtask

    // Every pixel yields exactly one result, so an empty queue means the
    // pipeline is empty and the registers may be touched
    task automatic drain_pipeline();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_blends.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        start      = 1'b0;
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------

    function automatic t_stim_row reg_row(logic [CFG_IDX_BITS-1:0] idx, int val);
        t_stim_row row;
        row         = '{kind: ROW_WRITE, reg_idx: idx, reg_val: val[CFG_DATA_BITS-1:0],
                        pix: '0, known: 1'b0, want: '0};
        return row;
    endfunction

    function automatic t_stim_row pix_row(int x, int y, int r, int g, int b);
        t_stim_row row;
        row     = '{kind: ROW_PIXEL, reg_idx: '0, reg_val: '0, pix: '0, known: 1'b0, want: '0};
        row.pix = '{x: x[COORD_BITS-1:0], y: y[COORD_BITS-1:0], red: r[COLOR_BITS-1:0],
                    green: g[COLOR_BITS-1:0], blue: b[COLOR_BITS-1:0]};
        return row;
    endfunction

    function automatic t_stim_row known_row(int x, int y, int r, int g, int b,
                                            int kr, int kg, int kb, bit kin);
        t_stim_row row;
        row       = pix_row(x, y, r, g, b);
        row.known = 1'b1;
        row.want  = '{red: kr[COLOR_BITS-1:0], green: kg[COLOR_BITS-1:0],
                      blue: kb[COLOR_BITS-1:0], hit: kin};
        return row;
    endfunction

    // Random helpers, leaning on the extremes
    function automatic logic [COLOR_BITS-1:0] rand_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return LEVEL_MAX[COLOR_BITS-1:0];
            default: return COLOR_BITS'($urandom_range(0, LEVEL_MAX));
        endcase
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return COORD_MAX[COORD_BITS-1:0];
            default: return COORD_BITS'($urandom_range(0, COORD_MAX));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        t_circle setting;
        t_pixel  p;
        int      span, px, py;

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_pixel_x     = '0;
        i_pixel_y     = '0;
        i_in_red      = '0;
        i_in_green    = '0;
        i_in_blue     = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        cur_known     = 1'b0;
        cur_want      = '0;
        error_count   = 0;
        cycle_count   = 0;
        result_count  = 0;
        inside_count  = 0;
        pixel_count   = 0;
        setting_count = 1;
        burst_left    = 0;

        // Reset defaults: centre (0,0), radius 30, black paint, opacity 51
        directed.push_back(known_row(0, 0, 255, 255, 255, 204, 204, 204, 1'b1));
        directed.push_back(known_row(30, 0, 12, 34, 56, 12, 34, 56, 1'b0));   // on the rim
        directed.push_back(known_row(4095, 4095, 0, 0, 0, 0, 0, 0, 1'b0));
        directed.push_back(pix_row(29, 0, 200, 100, 50));
        // Widest circle in the far corner, full opacity
        directed.push_back(reg_row(CFG_CENTER_X, 4095));
        directed.push_back(reg_row(CFG_CENTER_Y, 4095));
        directed.push_back(reg_row(CFG_RADIUS, 255));
        directed.push_back(reg_row(CFG_PAINT_RED, 255));
        directed.push_back(reg_row(CFG_PAINT_GREEN, 0));
        directed.push_back(reg_row(CFG_PAINT_BLUE, 128));
        directed.push_back(reg_row(CFG_OPACITY, 255));
        directed.push_back(known_row(4095, 4095, 0, 255, 0, 254, 0, 127, 1'b1));
        directed.push_back(known_row(3840, 4095, 9, 8, 7, 9, 8, 7, 1'b0));     // on the rim
        directed.push_back(pix_row(3841, 4095, 255, 255, 255));
        directed.push_back(pix_row(3900, 3900, 1, 2, 3));
        directed.push_back(pix_row(3915, 3915, 77, 0, 255));
        directed.push_back(known_row(0, 0, 255, 255, 255, 255, 255, 255, 1'b0));
        // Zero radius: nothing is inside, not even the centre
        directed.push_back(reg_row(CFG_RADIUS, 0));
        directed.push_back(known_row(4095, 4095, 1, 2, 3, 1, 2, 3, 1'b0));
        directed.push_back(known_row(4000, 4000, 255, 255, 255, 255, 255, 255, 1'b0));
        // Unit radius, zero opacity: inside but colour untouched
        directed.push_back(reg_row(CFG_CENTER_X, 2048));
        directed.push_back(reg_row(CFG_CENTER_Y, 2048));
        directed.push_back(reg_row(CFG_RADIUS, 1));
        directed.push_back(reg_row(CFG_PAINT_GREEN, 255));
        directed.push_back(reg_row(CFG_PAINT_BLUE, 255));
        directed.push_back(reg_row(CFG_OPACITY, 0));
        directed.push_back(known_row(2048, 2048, 10, 20, 30, 10, 20, 30, 1'b1));
        directed.push_back(known_row(2049, 2048, 5, 6, 7, 5, 6, 7, 1'b0));
        // Write past the register map must leave the centre alone
        directed.push_back(reg_row(CFG_SPARE_IDX, 4095));
        directed.push_back(reg_row(CFG_OPACITY, 128));
        directed.push_back(known_row(2048, 2048, 0, 0, 0, 127, 127, 127, 1'b1));
        directed.push_back(pix_row(2047, 2047, 100, 100, 100));
        // Mid-size circle, checked against the predictor
        directed.push_back(reg_row(CFG_CENTER_X, 100));
        directed.push_back(reg_row(CFG_CENTER_Y, 50));
        directed.push_back(reg_row(CFG_RADIUS, 100));
        directed.push_back(reg_row(CFG_PAINT_RED, 200));
        directed.push_back(reg_row(CFG_PAINT_GREEN, 100));
        directed.push_back(reg_row(CFG_PAINT_BLUE, 50));
        directed.push_back(reg_row(CFG_OPACITY, 200));
        directed.push_back(pix_row(0, 50, 0, 0, 0));
        directed.push_back(pix_row(100, 50, 255, 0, 255));
        directed.push_back(pix_row(150, 80, 30, 60, 90));
        directed.push_back(pix_row(100, 149, 255, 255, 0));
        directed.push_back(pix_row(0, 0, 128, 128, 128));

        // Single reset at the start of the run
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table
        foreach (directed[i]) begin
            if (directed[i].kind == ROW_WRITE) begin
                drain_pipeline();
                write_reg(directed[i].reg_idx, directed[i].reg_val);
            end else begin
                pace_sender();
                send_pixel(directed[i].pix, directed[i].known, directed[i].want);
            end
        end
        setting_count += 4;

        // Random circles; most pixels land in a box around the circle so
        // the blend path sees plenty of traffic, the rest go anywhere
        for (int s = 0; s < RAND_SETTINGS; s++) begin
            case ($urandom_range(0, 7))
                0:       setting.radius = '0;
                1:       setting.radius = 8'd1;
                2:       setting.radius = 8'd255;
                default: setting.radius = RAD_BITS'($urandom_range(2, 254));
            endcase
            setting.cx      = rand_coord();
            setting.cy      = rand_coord();
            setting.paint_r = rand_level();
            setting.paint_g = rand_level();
            setting.paint_b = rand_level();
            setting.opacity = rand_level();

            drain_pipeline();
            write_reg(CFG_CENTER_X, setting.cx);
            write_reg(CFG_CENTER_Y, setting.cy);
            write_reg(CFG_RADIUS, CFG_DATA_BITS'(setting.radius));
            write_reg(CFG_PAINT_RED, CFG_DATA_BITS'(setting.paint_r));
            write_reg(CFG_PAINT_GREEN, CFG_DATA_BITS'(setting.paint_g));
            write_reg(CFG_PAINT_BLUE, CFG_DATA_BITS'(setting.paint_b));
            write_reg(CFG_OPACITY, CFG_DATA_BITS'(setting.opacity));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_SPARE_IDX, CFG_DATA_BITS'($urandom_range(0, COORD_MAX)));
            setting_count++;

            span = int'(setting.radius) + 3;
            for (int n = 0; n < PIXELS_PER; n++) begin
                if ($urandom_range(0, 9) < 7) begin
                    px = int'(setting.cx) + $urandom_range(0, 2 * span) - span;
                    py = int'(setting.cy) + $urandom_range(0, 2 * span) - span;
                    px = (px < 0) ? 0 : (px > COORD_MAX) ? COORD_MAX : px;
                    py = (py < 0) ? 0 : (py > COORD_MAX) ? COORD_MAX : py;
                    p.x = px[COORD_BITS-1:0];
                    p.y = py[COORD_BITS-1:0];
                end else begin
                    p.x = rand_coord();
                    p.y = rand_coord();
                end
                p.red   = rand_level();
                p.green = rand_level();
                p.blue  = rand_level();
                pace_sender();
                send_pixel(p, 1'b0, '0);
            end
        end

        // Let the last transactions come out, then a little slack for strays
        drain_pipeline();
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);

        $display("Ran %0d pixels through %0d circle settings; %0d results, %0d blended",
                 pixel_count, setting_count, result_count, inside_count);
        $display("%0d mismatches, %0d results never arrived",
                 error_count, pending_blends.size());
        if (error_count == 0 && pending_blends.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/scpb_pkg.sv
sv/scpb_dist.sv
sv/scpb_sqrt.sv
sv/scpb_div.sv
sv/scpb_mix.sv
sv/soft_circle_pixel_blend.sv
dv/soft_circle_pixel_blend_tb.sv
